// ===== hdl/iee_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// iee_pkg
// shared types, character codes and helpers of the infix expression evaluator
// ----------------------------------------------------------------------------
package iee_pkg;

   localparam int VALUE_WIDTH_DEF   = 48;
   localparam int FRACTION_BITS_DEF = 16;
   localparam int QUEUE_DEPTH       = 4;

   // ascii codes the front end recognizes
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_SPACE = 8'h20;

   typedef enum logic [1:0] {
      TK_DIGIT = 2'd0,
      TK_OP    = 2'd1,
      TK_SPACE = 2'd2,
      TK_STRAY = 2'd3
   } tok_kind_type;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_DIVZ = 2'd1,
      ST_SAT  = 2'd2,
      ST_MALF = 2'd3
   } status_type;

   // one classified character
   typedef struct packed {
      tok_kind_type kind;
      logic [3:0]   digit;
      op_type       op;
      logic         last;
   } tok_type;

   // token queue status
   typedef struct packed {
      logic empty;
      logic full;
   } q_stat_type;

   // sticky status keeps the highest code
   function automatic status_type raise_st(status_type cur, status_type s);
      return (s > cur) ? s : cur;
   endfunction

   // high precedence for multiply and divide
   function automatic logic prec_hi(op_type o);
      return (o == OP_MUL) || (o == OP_DIV);
   endfunction

endpackage
`default_nettype wire

// ===== hdl/infix_expression_evaluator_core.sv =====
`default_nettype none
// A digit, space or stray character is handled in S_IDLE as it leaves the queue. An
// operator moves to S_REDUCE, which applies stacked operations of equal or higher
// precedence: add or subtract in S_APPLY, multiply via S_APPLY, an S_MUL shift-add loop
// and S_FIN, divide via S_APPLY, an S_DIV restoring divider loop and S_FIN. A last
// non-operator passes S_PUSH; S_DONE sends the result. Only S_IDLE pops the queue.
// Reset (synchronous, active high) empties the 4-entry queue and clears stacks and status.
// ----------------------------------------------------------------------------
// infix_expression_evaluator_core
// character-serial infix evaluator with precedence stacks and fixed point math
// ----------------------------------------------------------------------------
module infix_expression_evaluator_core import iee_pkg::*; #(
   parameter int VALUE_WIDTH   = VALUE_WIDTH_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [7:0]               req_char_code,
   input  wire logic                     req_last_char,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic signed [VALUE_WIDTH-1:0] rsp_value,
   output logic [1:0]                    rsp_status
);

   q_stat_type q_stat;
   logic       q_push, q_pop;
   tok_type    push_tok, q_tok;

   // classification front end
   iee_front u_front (
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_char_code (req_char_code),
      .req_last_char (req_last_char),
      .q_stat        (q_stat),
      .push          (q_push),
      .push_tok      (push_tok)
   );

   // token queue
   iee_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_tok (push_tok),
      .pop      (q_pop),
      .pop_tok  (q_tok),
      .stat     (q_stat)
   );

   // evaluation engine
   iee_back #(
      .VALUE_WIDTH   (VALUE_WIDTH),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_stat     (q_stat),
      .q_tok      (q_tok),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_value  (rsp_value),
      .rsp_status (rsp_status)
   );

`ifndef SYNTHESIS
   // no write into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_stat.full)
      else $error("token queue written while full");

   // no read from an empty queue
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_stat.empty)
      else $error("token queue read while empty");

   // a malformed expression reports a zero value
   a_malf_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_MALF) |-> (rsp_value == '0))
      else $error("malformed result with nonzero value");
`endif

endmodule
`default_nettype wire

// ===== hdl/iee_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// iee_front
// accepts characters and classifies them into tokens for the queue
// ----------------------------------------------------------------------------
module iee_front import iee_pkg::*; (
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_char_code,
   input  wire logic       req_last_char,
   input  wire q_stat_type q_stat,
   output logic            push,
   output tok_type         push_tok
);

   // take a word whenever the queue has room
   assign req_stall = q_stat.full;
   assign push      = req_valid && !q_stat.full;

   // character classification
   always_comb begin
      push_tok.kind  = TK_STRAY;
      push_tok.digit = req_char_code[3:0];
      push_tok.op    = OP_ADD;
      push_tok.last  = req_last_char;
      case (req_char_code) inside
         [CH_ZERO:CH_NINE]: push_tok.kind = TK_DIGIT;
         CH_PLUS: begin
            push_tok.kind = TK_OP;
            push_tok.op   = OP_ADD;
         end
         CH_MINUS: begin
            push_tok.kind = TK_OP;
            push_tok.op   = OP_SUB;
         end
         CH_STAR: begin
            push_tok.kind = TK_OP;
            push_tok.op   = OP_MUL;
         end
         CH_SLASH: begin
            push_tok.kind = TK_OP;
            push_tok.op   = OP_DIV;
         end
         CH_SPACE: push_tok.kind = TK_SPACE;
         default:  push_tok.kind = TK_STRAY;
      endcase
   end

endmodule
`default_nettype wire

// ===== hdl/iee_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// iee_queue
// small token fifo between the front end and the evaluation engine
// ----------------------------------------------------------------------------
module iee_queue import iee_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire tok_type push_tok,
   input  wire logic    pop,
   output tok_type      pop_tok,
   output q_stat_type   stat
);

   localparam int AW = $clog2(QUEUE_DEPTH);

   tok_type        mem_ff [QUEUE_DEPTH];
   logic [AW-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]    cnt_ff, cnt_in;

   assign pop_tok    = mem_ff[rd_ff];
   assign stat.empty = (cnt_ff == '0);
   assign stat.full  = (cnt_ff == (AW+1)'(QUEUE_DEPTH));

   // pointer and fill update
   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_tok;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/iee_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// iee_back
// evaluation engine: number build, stacks, sequenced add, multiply, divide
// ----------------------------------------------------------------------------
module iee_back import iee_pkg::*; #(
   parameter int VALUE_WIDTH   = VALUE_WIDTH_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire q_stat_type             q_stat,
   input  wire tok_type                q_tok,
   output logic                        q_pop,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic signed [VALUE_WIDTH-1:0] rsp_value,
   output logic [1:0]                  rsp_status
);

   localparam int W  = VALUE_WIDTH;
   localparam int F  = FRACTION_BITS;
   localparam int AW = ((W > F + 4) ? W : F + 4) + 4;
   localparam int NW = W + F;
   localparam int PW = 2 * W;
   localparam int MW = (PW > NW) ? PW : NW;
   localparam int CW = $clog2(NW + 1);

   localparam logic [W-1:0]  MAXV     = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0]  MINV     = {1'b1, {(W-1){1'b0}}};
   localparam logic [CW-1:0] MUL_LAST = CW'(W - 1);
   localparam logic [CW-1:0] DIV_LAST = CW'(NW - 1);

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_PUSH   = 8'b0000_0010,
      S_REDUCE = 8'b0000_0100,
      S_APPLY  = 8'b0000_1000,
      S_MUL    = 8'b0001_0000,
      S_DIV    = 8'b0010_0000,
      S_FIN    = 8'b0100_0000,
      S_DONE   = 8'b1000_0000
   } state_type;

   state_type       state_ff, state_in;
   logic [W-1:0]    vs0_ff, vs0_in, vs1_ff, vs1_in, vs2_ff, vs2_in;
   logic [1:0]      vc_ff, vc_in, opc_ff, opc_in;
   op_type          os0_ff, os0_in, os1_ff, os1_in;
   logic [W-1:0]    acc_ff, acc_in;
   logic            in_num_ff, in_num_in;
   status_type      st_ff, st_in;
   tok_type         tok_ff, tok_in;
   logic            fin_ff, fin_in;
   op_type          cur_op_ff, cur_op_in;
   logic            neg_ff, neg_in;
   logic [PW-1:0]   prod_ff, prod_in, mcand_ff, mcand_in;
   logic [W-1:0]    mplier_ff, mplier_in;
   logic [NW-1:0]   num_ff, num_in;
   logic [W:0]      rem_ff, rem_in;
   logic [W-1:0]    dvsr_ff, dvsr_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]    rsp_value_ff, rsp_value_in;
   status_type      rsp_status_ff, rsp_status_in;

   // operand selection from the stack top
   op_type          top_op;
   logic [W-1:0]    opa, opb, mag_a, mag_b;
   logic [W:0]      sum;
   logic [W-1:0]    add_res;
   logic            add_sat;
   logic [AW-1:0]   dig_wide;
   logic [W:0]      div_sh;
   logic            div_ge;
   logic [MW-1:0]   fin_mag, fin_lim;
   logic [W-1:0]    res_mag, fin_res;
   logic            fin_sat;
   logic            do_push, wb;
   logic [W-1:0]    wb_val;
   status_type      st_fin;

   assign top_op = (opc_ff == 2'd2) ? os1_ff : os0_ff;
   assign opa    = (vc_ff == 2'd3) ? vs1_ff : vs0_ff;
   assign opb    = (vc_ff == 2'd3) ? vs2_ff : vs1_ff;
   assign mag_a  = opa[W-1] ? (~opa + W'(1)) : opa;
   assign mag_b  = opb[W-1] ? (~opb + W'(1)) : opb;

   // saturating add and subtract
   always_comb begin
      if (top_op == OP_SUB) begin
         sum = {opa[W-1], opa} - {opb[W-1], opb};
      end else begin
         sum = {opa[W-1], opa} + {opb[W-1], opb};
      end
      add_sat = (sum[W] != sum[W-1]);
      if (add_sat) begin
         add_res = sum[W] ? MINV : MAXV;
      end else begin
         add_res = sum[W-1:0];
      end
   end

   // decimal digit into the accumulator
   assign dig_wide = (AW'(acc_ff) << 3) + (AW'(acc_ff) << 1) + (AW'(q_tok.digit) << F);

   // one restoring division step
   assign div_sh = {rem_ff[W-1:0], num_ff[NW-1]};
   assign div_ge = (div_sh >= {1'b0, dvsr_ff});

   // result scaling, saturation and sign
   always_comb begin
      if (cur_op_ff == OP_MUL) begin
         fin_mag = MW'(prod_ff >> F);
      end else begin
         fin_mag = MW'(num_ff);
      end
      fin_lim = MW'(MAXV) + MW'(neg_ff);
      fin_sat = (fin_mag > fin_lim);
      res_mag = fin_sat ? fin_lim[W-1:0] : fin_mag[W-1:0];
      fin_res = neg_ff ? (~res_mag + W'(1)) : res_mag;
   end

   assign st_fin = (vc_ff != 2'd1) ? raise_st(st_ff, ST_MALF) : st_ff;
   assign q_pop  = (state_ff == S_IDLE) && !q_stat.empty;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      vs0_in        = vs0_ff;
      vs1_in        = vs1_ff;
      vs2_in        = vs2_ff;
      vc_in         = vc_ff;
      opc_in        = opc_ff;
      os0_in        = os0_ff;
      os1_in        = os1_ff;
      acc_in        = acc_ff;
      in_num_in     = in_num_ff;
      st_in         = st_ff;
      tok_in        = tok_ff;
      fin_in        = fin_ff;
      cur_op_in     = cur_op_ff;
      neg_in        = neg_ff;
      prod_in       = prod_ff;
      mcand_in      = mcand_ff;
      mplier_in     = mplier_ff;
      num_in        = num_ff;
      rem_in        = rem_ff;
      dvsr_in       = dvsr_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      do_push       = 1'b0;
      wb            = 1'b0;
      wb_val        = add_res;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (!q_stat.empty) begin
               tok_in = q_tok;
               fin_in = 1'b0;
               case (q_tok.kind)
                  TK_DIGIT: begin
                     in_num_in = 1'b1;
                     if (dig_wide > AW'(MAXV)) begin
                        acc_in = MAXV;
                        st_in  = raise_st(st_in, ST_SAT);
                     end else begin
                        acc_in = dig_wide[W-1:0];
                     end
                  end
                  TK_OP: begin
                     if (!in_num_ff) begin
                        st_in = raise_st(st_in, ST_MALF);
                     end
                     do_push  = 1'b1;
                     state_in = S_REDUCE;
                  end
                  TK_SPACE: begin
                  end
                  default: st_in = raise_st(st_in, ST_MALF);
               endcase
               if (q_tok.kind != TK_OP && q_tok.last) begin
                  fin_in   = 1'b1;
                  state_in = S_PUSH;
               end
            end
         end
         S_PUSH: begin
            do_push  = 1'b1;
            state_in = S_REDUCE;
         end
         S_REDUCE: begin
            if (!fin_ff) begin
               if (opc_ff != 2'd0 && (prec_hi(tok_ff.op) <= prec_hi(top_op))) begin
                  state_in = S_APPLY;
               end else begin
                  if (opc_ff == 2'd0) begin
                     os0_in = tok_ff.op;
                     opc_in = 2'd1;
                  end else if (opc_ff == 2'd1) begin
                     os1_in = tok_ff.op;
                     opc_in = 2'd2;
                  end else begin
                     st_in = raise_st(st_in, ST_MALF);
                  end
                  if (tok_ff.last) begin
                     fin_in = 1'b1;
                  end else begin
                     state_in = S_IDLE;
                  end
               end
            end else if (opc_ff != 2'd0) begin
               state_in = S_APPLY;
            end else begin
               state_in = S_DONE;
            end
         end
         S_APPLY: begin
            opc_in    = opc_ff - 2'd1;
            cur_op_in = top_op;
            neg_in    = opa[W-1] ^ opb[W-1];
            state_in  = S_REDUCE;
            if (vc_ff < 2'd2) begin
               st_in = raise_st(st_in, ST_MALF);
            end else begin
               case (top_op)
                  OP_MUL: begin
                     prod_in   = '0;
                     mcand_in  = PW'(mag_a);
                     mplier_in = mag_b;
                     cnt_in    = '0;
                     state_in  = S_MUL;
                  end
                  OP_DIV: begin
                     if (mag_b == '0) begin
                        st_in  = raise_st(st_in, ST_DIVZ);
                        wb     = 1'b1;
                        wb_val = '0;
                     end else begin
                        num_in   = NW'(mag_a) << F;
                        rem_in   = '0;
                        dvsr_in  = mag_b;
                        cnt_in   = '0;
                        state_in = S_DIV;
                     end
                  end
                  default: begin
                     wb = 1'b1;
                     if (add_sat) begin
                        st_in = raise_st(st_in, ST_SAT);
                     end
                  end
               endcase
            end
         end
         S_MUL: begin
            if (mplier_ff[0]) begin
               prod_in = prod_ff + mcand_ff;
            end
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == MUL_LAST) begin
               state_in = S_FIN;
            end
         end
         S_DIV: begin
            rem_in = div_ge ? (div_sh - {1'b0, dvsr_ff}) : div_sh;
            num_in = {num_ff[NW-2:0], div_ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            wb     = 1'b1;
            wb_val = fin_res;
            if (fin_sat) begin
               st_in = raise_st(st_in, ST_SAT);
            end
            state_in = S_REDUCE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = (st_fin == ST_MALF) ? '0 : vs0_ff;
               rsp_status_in = st_fin;
               vc_in         = 2'd0;
               opc_in        = 2'd0;
               acc_in        = '0;
               in_num_in     = 1'b0;
               st_in         = ST_OK;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // pending number onto the value stack
      if (do_push && in_num_ff) begin
         case (vc_ff)
            2'd0:    vs0_in = acc_ff;
            2'd1:    vs1_in = acc_ff;
            2'd2:    vs2_in = acc_ff;
            default: st_in  = raise_st(st_in, ST_MALF);
         endcase
         if (vc_ff != 2'd3) begin
            vc_in = vc_ff + 2'd1;
         end
         in_num_in = 1'b0;
         acc_in    = '0;
      end

      // result replaces the two top operands
      if (wb) begin
         if (vc_ff == 2'd3) begin
            vs1_in = wb_val;
            vc_in  = 2'd2;
         end else begin
            vs0_in = wb_val;
            vc_in  = 2'd1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         vc_ff        <= 2'd0;
         opc_ff       <= 2'd0;
         acc_ff       <= '0;
         in_num_ff    <= 1'b0;
         st_ff        <= ST_OK;
         fin_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vc_ff        <= vc_in;
         opc_ff       <= opc_in;
         acc_ff       <= acc_in;
         in_num_ff    <= in_num_in;
         st_ff        <= st_in;
         fin_ff       <= fin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      vs0_ff        <= vs0_in;
      vs1_ff        <= vs1_in;
      vs2_ff        <= vs2_in;
      os0_ff        <= os0_in;
      os1_ff        <= os1_in;
      tok_ff        <= tok_in;
      cur_op_ff     <= cur_op_in;
      neg_ff        <= neg_in;
      prod_ff       <= prod_in;
      mcand_ff      <= mcand_in;
      mplier_ff     <= mplier_in;
      num_ff        <= num_in;
      rem_ff        <= rem_in;
      dvsr_ff       <= dvsr_in;
      cnt_ff        <= cnt_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = $signed(rsp_value_ff);
   assign rsp_status = rsp_status_ff;

endmodule
`default_nettype wire

// ===== tb/infix_expression_evaluator_core_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_expression_evaluator_core_checker
// watches both channels, evaluates each expression on its own and compares
// every result word with the oldest expected one
// ----------------------------------------------------------------------------
module infix_expression_evaluator_core_checker import iee_pkg::*; #(
   parameter int VALUE_WIDTH   = VALUE_WIDTH_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [7:0]             req_char_code,
   input  logic                   req_last_char,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic [VALUE_WIDTH-1:0] rsp_value,
   input  logic [1:0]             rsp_status,
   output int                     fail_count,
   output int                     pending_count
);

   typedef logic [VALUE_WIDTH-1:0] val_type;
   typedef struct {
      val_type    value;
      status_type status;
   } eval_result_type;

   // evaluator state
   val_type    vals [3];
   int         nvals;
   op_type     ops [2];
   int         nops;
   val_type    accum;
   bit         in_num;
   status_type sticky;
   eval_result_type expected_results [$];

   localparam logic [127:0] MAX_POS = (128'd1 << (VALUE_WIDTH - 1)) - 1;

   function automatic void raise(status_type s);
      if (s > sticky) sticky = s;
   endfunction

   // saturate a sign and magnitude into the value range
   function automatic val_type clamp(bit neg, logic [127:0] m);
      logic [127:0] lim;
      lim = neg ? MAX_POS + 1 : MAX_POS;
      if (m > lim) begin
         raise(ST_SAT);
         m = lim;
      end
      return neg ? val_type'(-m) : val_type'(m);
   endfunction

   // magnitude of a value, negated at value width
   function automatic logic [127:0] mag(val_type x);
      val_type n;
      n = -x;
      return x[VALUE_WIDTH-1] ? 128'(n) : 128'(x);
   endfunction

   function automatic val_type add_sm(bit na, logic [127:0] ma, bit nb, logic [127:0] mb);
      if (na == nb) return clamp(na, ma + mb);
      if (ma >= mb) return clamp(na, ma - mb);
      return clamp(nb, mb - ma);
   endfunction

   function automatic val_type calc(op_type op, val_type a, val_type b);
      bit neg;
      logic [127:0] p;
      neg = a[VALUE_WIDTH-1] ^ b[VALUE_WIDTH-1];
      case (op)
         OP_ADD: return add_sm(a[VALUE_WIDTH-1], mag(a), b[VALUE_WIDTH-1], mag(b));
         OP_SUB: return add_sm(a[VALUE_WIDTH-1], mag(a),
                               !b[VALUE_WIDTH-1] && b != 0, mag(b));
         OP_MUL: begin
            p = (mag(a) * mag(b)) >> FRACTION_BITS;
            return clamp(neg, p);
         end
         default: begin
            if (mag(b) == 0) begin
               raise(ST_DIVZ);
               return '0;
            end
            p = (mag(a) << FRACTION_BITS) / mag(b);
            return clamp(neg, p);
         end
      endcase
   endfunction

   function automatic void apply_top();
      op_type op;
      if (nops == 0) return;
      nops--;
      op = ops[nops];
      if (nvals < 2) begin
         raise(ST_MALF);
         return;
      end
      vals[nvals-2] = calc(op, vals[nvals-2], vals[nvals-1]);
      nvals--;
   endfunction

   function automatic void push_num();
      if (!in_num) return;
      if (nvals < 3) begin
         vals[nvals] = accum;
         nvals++;
      end else raise(ST_MALF);
      in_num = 0;
      accum = '0;
   endfunction

   function automatic void clear_eval();
      foreach (vals[i]) vals[i] = '0;
      nvals = 0;
      nops = 0;
      accum = '0;
      in_num = 0;
      sticky = ST_OK;
   endfunction

   // advance the evaluator by one character word
   function automatic void eval_char(logic [7:0] c, bit last);
      bit is_op;
      op_type op;
      eval_result_type r;
      is_op = 1;
      op = OP_ADD;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         accum = clamp(0, 128'(accum) * 10 + (128'(c - CH_ZERO) << FRACTION_BITS));
         in_num = 1;
         is_op = 0;
      end else if (c == CH_PLUS) op = OP_ADD;
      else if (c == CH_MINUS) op = OP_SUB;
      else if (c == CH_STAR) op = OP_MUL;
      else if (c == CH_SLASH) op = OP_DIV;
      else begin
         is_op = 0;
         if (c != CH_SPACE) raise(ST_MALF);
      end
      if (is_op) begin
         if (!in_num) raise(ST_MALF);
         push_num();
         while (nops > 0 && prec_hi(op) <= prec_hi(ops[nops-1])) apply_top();
         if (nops < 2) begin
            ops[nops] = op;
            nops++;
         end else raise(ST_MALF);
      end
      if (!last) return;
      push_num();
      while (nops > 0) apply_top();
      if (nvals != 1) raise(ST_MALF);
      r.value = (sticky == ST_MALF) ? '0 : vals[0];
      r.status = sticky;
      expected_results.push_back(r);
      clear_eval();
   endfunction

   initial begin
      fail_count = 0;
      clear_eval();
   end

   assign pending_count = expected_results.size();

   // sample accepted words at the rising edge
   always @(posedge clock) begin
      eval_result_type e;
      if (reset) begin
         clear_eval();
      end else begin
         if (req_valid && !req_stall) eval_char(req_char_code, req_last_char);
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result word value=%0h status=%0d", rsp_value, rsp_status);
               fail_count++;
            end else begin
               e = expected_results.pop_front();
               if (rsp_value !== e.value) begin
                  $error("value: expected %0h actual %0h", e.value, rsp_value);
                  fail_count++;
               end
               if (rsp_status !== e.status) begin
                  $error("status: expected %0d actual %0d", e.status, rsp_status);
                  fail_count++;
               end
            end
         end
      end
   end

endmodule

// ===== tb/infix_expression_evaluator_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_expression_evaluator_core_tb
// feeds directed and random infix expressions with random idling and long
// receiver hold-offs; the checker predicts and compares the results
// ----------------------------------------------------------------------------
module infix_expression_evaluator_core_tb;
   import iee_pkg::*;

   localparam int VW = VALUE_WIDTH_DEF;
   localparam int WATCHDOG_LIMIT = 20000;

   logic          clock = 0;
   logic          reset = 1;
   logic          req_valid = 0;
   logic          req_stall;
   logic [7:0]    req_char_code = CH_SPACE;
   logic          req_last_char = 0;
   logic          rsp_valid;
   logic          rsp_stall = 0;
   logic [VW-1:0] rsp_value;
   logic [1:0]    rsp_status;
   int            fail_count;
   int            pending_count;
   bit            quiet_phase = 0;
   bit            hold_off = 0;
   int            idle_cycles = 0;
   bit            stim_done = 0;
   int            words_sent = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   infix_expression_evaluator_core dut (
      .clock, .reset, .req_valid, .req_stall, .req_char_code, .req_last_char,
      .rsp_valid, .rsp_stall, .rsp_value, .rsp_status
   );

   infix_expression_evaluator_core_checker chk (
      .clock, .reset, .req_valid, .req_stall, .req_char_code, .req_last_char,
      .rsp_valid, .rsp_stall, .rsp_value, .rsp_status, .fail_count, .pending_count
   );

   // send one character word, with random idle gaps before it
   task automatic send_word(logic [7:0] c, bit last);
      while (!quiet_phase && $urandom_range(99) < 14) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid     <= 1;
      req_char_code <= c;
      req_last_char <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_word(s[i], i == s.len() - 1);
   endtask

   function automatic logic [7:0] pick_op();
      case ($urandom_range(3))
         0: return CH_PLUS;
         1: return CH_MINUS;
         2: return CH_STAR;
         default: return CH_SLASH;
      endcase
   endfunction

   // well-formed expression with random operands, spaces and operators
   task automatic send_random_expr();
      int nterms;
      int ndig;
      nterms = $urandom_range(1, 4);
      for (int t = 0; t < nterms; t++) begin
         ndig = ($urandom_range(9) == 0) ? $urandom_range(8, 16) : $urandom_range(1, 3);
         if ($urandom_range(7) == 0) send_word(CH_SPACE, 0);
         for (int d = 0; d < ndig; d++) begin
            if ($urandom_range(20) == 0) send_word(CH_SPACE, 0);
            send_word(8'(CH_ZERO + $urandom_range(9)), 0);
         end
         if ($urandom_range(9) == 0) send_word(CH_SPACE, 0);
         if (t != nterms - 1) send_word(pick_op(), 0);
      end
      send_word(($urandom_range(5) == 0) ? CH_SPACE : 8'(CH_ZERO + $urandom_range(9)), 1);
   endtask

   // noise: any byte, with a last mark on the final byte of each burst
   task automatic send_noise();
      int n;
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) send_word(8'($urandom), i == n - 1);
   endtask

   // receiver: random stalls, one long hold-off
   always @(negedge clock) begin
      if (hold_off) rsp_stall <= 1;
      else if (quiet_phase) rsp_stall <= 0;
      else rsp_stall <= ($urandom_range(99) < 14);
   end

   // watchdog on cycles with no accepted word
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || hold_off)
         idle_cycles <= 0;
      else if (!stim_done || pending_count != 0)
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed part
      send_text("0");
      send_text(" 12+3");
      send_text("7-9*2");
      send_text("8/3-1");
      send_text("5/0");
      send_text("999999999999*99");
      send_text("+4");
      send_text("2*/3");
      send_text("1+2*3-4/5");
      send_text("1 2?3");
      send_text(" ");
      send_word(8'hFF, 1);
      send_word(8'h00, 1);

      // long hold-off while the sender keeps going
      fork
         begin
            hold_off = 1;
            repeat (300) @(negedge clock);
            hold_off = 0;
         end
         for (int i = 0; i < 6; i++) send_random_expr();
      join
      req_valid <= 0;

      // pause until every result is back
      wait (pending_count == 0);
      repeat (20) @(negedge clock);

      for (int k = 0; words_sent < 1900; k++) begin
         quiet_phase = (k >= 40 && k < 70);
         if ($urandom_range(9) == 0) send_noise();
         else send_random_expr();
      end
      req_valid <= 0;
      quiet_phase = 0;
      stim_done = 1;

      wait (pending_count == 0);
      repeat (200) @(negedge clock);
      if (fail_count == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule
